### hw/rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, symbol codes and lookup functions of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int SYM_W   = 4;
    localparam int SYM_CNT = 13;
    localparam int VAL_W   = 12;
    localparam int WT_W    = 10;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 2;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [CHAR_W-1:0] CH_I = 8'h49;
    localparam logic [CHAR_W-1:0] CH_V = 8'h56;
    localparam logic [CHAR_W-1:0] CH_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D = 8'h44;
    localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_E = 8'h45;
    localparam logic [CHAR_W-1:0] CH_R = 8'h52;
    localparam logic [CHAR_W-1:0] CH_O = 8'h4F;

    typedef enum logic [SYM_W-1:0] {
        SYM_M,
        SYM_CM,
        SYM_D,
        SYM_CD,
        SYM_C,
        SYM_XC,
        SYM_L,
        SYM_XL,
        SYM_X,
        SYM_IX,
        SYM_V,
        SYM_IV,
        SYM_I,
        SYM_ZERO
    } t_sym;

    typedef enum logic {
        FE_IDLE,
        FE_RUN
    } t_fe_state;

    typedef struct packed {
        t_sym sym;
        logic last;
    } t_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [WT_W-1:0] sym_weight(input t_sym sym);
        logic [WT_W-1:0] w;
        case (sym)
            SYM_M:   w = 10'd1000;
            SYM_CM:  w = 10'd900;
            SYM_D:   w = 10'd500;
            SYM_CD:  w = 10'd400;
            SYM_C:   w = 10'd100;
            SYM_XC:  w = 10'd90;
            SYM_L:   w = 10'd50;
            SYM_XL:  w = 10'd40;
            SYM_X:   w = 10'd10;
            SYM_IX:  w = 10'd9;
            SYM_V:   w = 10'd5;
            SYM_IV:  w = 10'd4;
            SYM_I:   w = 10'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [POS_W-1:0] sym_len_m1(input t_sym sym);
        logic [POS_W-1:0] n;
        case (sym)
            SYM_CM, SYM_CD, SYM_XC, SYM_XL, SYM_IX, SYM_IV: n = 2'd1;
            SYM_ZERO: n = 2'd3;
            default:  n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] sym_char(input t_sym sym,
                                                   input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        logic              sec;
        sec = (pos != '0);
        case (sym)
            SYM_M:   ch = CH_M;
            SYM_CM:  ch = sec ? CH_M : CH_C;
            SYM_D:   ch = CH_D;
            SYM_CD:  ch = sec ? CH_D : CH_C;
            SYM_C:   ch = CH_C;
            SYM_XC:  ch = sec ? CH_C : CH_X;
            SYM_L:   ch = CH_L;
            SYM_XL:  ch = sec ? CH_L : CH_X;
            SYM_X:   ch = CH_X;
            SYM_IX:  ch = sec ? CH_X : CH_I;
            SYM_V:   ch = CH_V;
            SYM_IV:  ch = sec ? CH_V : CH_I;
            SYM_I:   ch = CH_I;
            SYM_ZERO: begin
                case (pos)
                    2'd0:    ch = CH_Z;
                    2'd1:    ch = CH_E;
                    2'd2:    ch = CH_R;
                    default: ch = CH_O;
                endcase
            end
            default: ch = CH_I;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front
// Splits values into greedy Roman symbols, one per cycle while queue has room.
// ----------------------------------------------------------------------------
module rne_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rne_pkg::VAL_W-1:0]  i_value,
    input  rne_pkg::t_q_stat           i_q_stat,
    output logic                       o_push,
    output rne_pkg::t_tok              o_tok
);
    import rne_pkg::*;

    t_fe_state        r_state;
    t_fe_state        n_state;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] n_rem;
    t_sym             sel;
    logic [VAL_W-1:0] sel_wt;
    logic             sel_last;

    always_comb begin
        sel = SYM_ZERO;
        for (int k = SYM_CNT - 1; k >= 0; k--) begin
            if (r_rem >= {{(VAL_W-WT_W){1'b0}}, sym_weight(t_sym'(SYM_W'(k)))}) begin
                sel = t_sym'(SYM_W'(k));
            end
        end
    end

    assign sel_wt   = {{(VAL_W-WT_W){1'b0}}, sym_weight(sel)};
    assign sel_last = (sel == SYM_ZERO) || (r_rem == sel_wt);
    assign o_tok    = '{sym: sel, last: sel_last};

    always_comb begin
        n_state = r_state;
        case (r_state)
            FE_IDLE: begin
                if (i_valid) begin
                    n_state = FE_RUN;
                end
            end
            FE_RUN: begin
                if (o_push && sel_last) begin
                    n_state = FE_IDLE;
                end
            end
            default: n_state = FE_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            FE_IDLE: o_ready = 1'b1;
            FE_RUN:  o_push  = !i_q_stat.full;
            default: o_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_rem = r_rem;
        if (i_valid && o_ready) begin
            n_rem = i_value;
        end else if (o_push) begin
            n_rem = r_rem - sel_wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem <= n_rem;
    end

endmodule

### hw/rtl/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue
// Small symbol queue between the front and the back.
// ----------------------------------------------------------------------------
module rne_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rne_pkg::t_tok     i_tok,
    input  logic              i_pop,
    output rne_pkg::t_tok     o_head,
    output rne_pkg::t_q_stat  o_stat
);
    import rne_pkg::*;

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign wr_en        = i_push && !o_stat.full;
    assign rd_en        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

### hw/rtl/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back
// Expands queued symbols into ASCII characters behind an output register.
// ----------------------------------------------------------------------------
module rne_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rne_pkg::t_tok               i_head,
    input  rne_pkg::t_q_stat            i_q_stat,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rne_pkg::CHAR_W-1:0]  o_char_code,
    output logic                        o_last
);
    import rne_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              load;
    logic              tok_end;

    assign load    = !i_q_stat.empty && (!r_valid || i_ready);
    assign tok_end = (r_pos == sym_len_m1(i_head.sym));
    assign o_pop   = load && tok_end;

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= tok_end ? '0 : r_pos + POS_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_char <= sym_char(i_head.sym, r_pos);
            r_last <= i_head.last && tok_end;
        end
    end

endmodule

### hw/rtl/roman_numeral_encoder_top.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top
// Writes a 12-bit unsigned value as a Roman numeral, one ASCII char per item.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready with i_value. Output channel: o_valid /
// i_ready with o_char_code and o_last; o_last marks the final character of a
// numeral. Zero gives Z E R O; values of 4000 and above begin with MMMM.
// The front takes one value at a time and splits it into greedy symbols
// (M, CM, D ... I), one symbol per cycle while the queue has room, into a
// four-entry queue. The back expands each symbol into one, two or four
// characters, one per cycle while the receiver is ready, through an output
// register. A value is registered in the front, its first symbol is written
// to the queue and then loaded into the output register. At most one
// character per cycle leaves; the front takes no new value until it has
// queued the last symbol of the current one (3888 has 15 symbols), and
// o_ready returns in the cycle after the front has queued its last symbol.
// When the receiver stalls, the output holds, the queue fills and the front
// waits. Reset empties the queue and the output register and returns the
// front to idle; no state carries from one value to the next.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rne_pkg::VAL_W-1:0]   i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rne_pkg::CHAR_W-1:0]  o_char_code,
    output logic                        o_last
);
    import rne_pkg::*;

    t_q_stat q_stat;
    t_tok    push_tok;
    t_tok    head_tok;
    logic    push;
    logic    pop;

    rne_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_value  (i_value),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_tok    (push_tok)
    );

    rne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_head  (head_tok),
        .o_stat  (q_stat)
    );

    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_tok),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

### hw/rtl/rne_checker.sv
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks of the Roman numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rne_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [rne_pkg::VAL_W-1:0]   i_value,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [rne_pkg::CHAR_W-1:0]  o_char_code,
    input logic                        o_last
);
    import rne_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !$isunknown(i_value))
        else $error("input value unknown while valid");

    a_one_value_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after accepting a value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_code) && $stable(o_last))
        else $error("stalled output changed");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CH_I || o_char_code == CH_V || o_char_code == CH_X
                  || o_char_code == CH_L || o_char_code == CH_C || o_char_code == CH_D
                  || o_char_code == CH_M || o_char_code == CH_Z || o_char_code == CH_E
                  || o_char_code == CH_R || o_char_code == CH_O))
        else $error("character outside the numeral alphabet");

endmodule

bind roman_numeral_encoder_top rne_checker u_rne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_value     (i_value),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the Roman numeral encoder against a greedy numeral predictor.
// ----------------------------------------------------------------------------
// Values go in on a valid/ready channel; characters come out one per item
// with a last-of-numeral flag. Each accepted value is expanded here into its
// expected characters, and every output item is compared with the oldest one.
// Directed values cover zero, the field extremes, every symbol and the
// longest numeral; random values run with both sides idling, with a stretch
// of back-to-back traffic and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rne_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_CHARS    = 15;
    localparam int IDLE_PCT     = 19;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int NUM_SYMS     = 13;

    localparam int unsigned SYM_VALUE [NUM_SYMS] =
        '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    localparam logic [CHAR_W-1:0] SYM_FIRST [NUM_SYMS] =
        '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
    localparam logic [CHAR_W-1:0] SYM_SECOND [NUM_SYMS] =
        '{CH_M, CH_M, CH_D, CH_D, CH_C, CH_C, CH_L, CH_L, CH_X, CH_X, CH_V, CH_V, CH_I};
    localparam bit SYM_IS_PAIR [NUM_SYMS] =
        '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

    typedef struct {
        logic [VAL_W-1:0]  value;
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } t_numeral_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [VAL_W-1:0]   i_value;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last;

    t_numeral_char pending_chars[$];
    int  values_sent   = 0;
    int  chars_checked = 0;
    int  errors        = 0;
    int  stall_cycles  = 0;
    int  hold_requests = 0;
    int  holds_done    = 0;
    int  hold_left     = 0;
    bit  steady        = 1'b0;

    roman_numeral_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void push_numeral(input logic [VAL_W-1:0] value);
        t_numeral_char chars[$];
        t_numeral_char c;
        int unsigned   remaining;
        int            k;
        remaining = 32'(value);
        c.value   = value;
        c.is_last = 1'b0;
        if (remaining == 0) begin
            c.code = CH_Z; chars.push_back(c);
            c.code = CH_E; chars.push_back(c);
            c.code = CH_R; chars.push_back(c);
            c.code = CH_O; chars.push_back(c);
        end else begin
            k = 0;
            while (remaining > 0 && k < NUM_SYMS) begin
                if (remaining >= SYM_VALUE[k]) begin
                    c.code = SYM_FIRST[k];
                    if (chars.size() < MAX_CHARS) chars.push_back(c);
                    if (SYM_IS_PAIR[k]) begin
                        c.code = SYM_SECOND[k];
                        if (chars.size() < MAX_CHARS) chars.push_back(c);
                    end
                    remaining -= SYM_VALUE[k];
                end else begin
                    k++;
                end
            end
        end
        if (chars.size() > 0) chars[chars.size()-1].is_last = 1'b1;
        foreach (chars[i]) pending_chars.push_back(chars[i]);
    endfunction

    task automatic send_value(input logic [VAL_W-1:0] value);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        push_numeral(value);
        values_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)  return '0;
        if (pick < 25) return VAL_W'($urandom_range(15));
        if (pick < 45) return VAL_W'($urandom_range(4095, 3000));
        return VAL_W'($urandom);
    endfunction

    task automatic test_directed();
        logic [VAL_W-1:0] values[$];
        values = '{0, 1, 4095, 3888, 4000, 3999, 4, 9, 40, 90, 400, 900, 5, 50,
                   500, 1000, 14, 2048, 1365, 2730, 10, 100, 3, 444};
        foreach (values[i]) send_value(values[i]);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        steady <= 1'b1;
        repeat (30) send_value(random_value());
        wait_drained();
        steady <= 1'b0;
    endtask

    task automatic test_output_hold_off();
        hold_requests <= hold_requests + 1;
        repeat (12) send_value(VAL_W'($urandom_range(3888, 2888)));
        wait_drained();
    endtask

    task automatic test_random();
        repeat (110) send_value(random_value());
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_numeral_char want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char 8'h%02h last=%0b", $time, o_char_code, o_last);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code || o_last !== want.is_last) begin
                    $display("%0t: value %0d: expected char %s last=%0b, got 8'h%02h last=%0b",
                             $time, want.value, want.code, want.is_last, o_char_code, o_last);
                    errors++;
                end
                chars_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_back_to_back();
        test_output_hold_off();
        test_random();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d expected chars never arrived", $time, pending_chars.size());
            errors++;
        end
        $display("Encoded %0d values into %0d checked chars, %0d mismatches.",
                 values_sent, chars_checked, errors);
        $display("Covered zero, field extremes, all symbols, back-to-back and output hold-off.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
